// ===== hw/rtl/acp_pkg.sv =====
// Shared types and widths for the box versus capsule collision push unit.
package acp_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 32;              // signed coordinate width
  localparam int MAG_W   = COORD_W - 1;     // sizes, radius, in-range distances
  localparam int EXT_W   = COORD_W + 2;     // clamped points and segment ends
  localparam int DIFF_W  = COORD_W + 3;     // axis minus box point
  localparam int SQ_W    = 2 * MAG_W;       // one squared component
  localparam int SUM_W   = SQ_W + 2;        // sum of three squares
  localparam int STEPS   = MAG_W;           // root and quotient bits, one per stage

  // Request payload.
  typedef struct packed {
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_z;
    logic        [MAG_W-1:0]   box_size_x;
    logic        [MAG_W-1:0]   box_size_y;
    logic        [MAG_W-1:0]   box_size_z;
    logic signed [COORD_W-1:0] cap_x;
    logic signed [COORD_W-1:0] cap_y;
    logic signed [COORD_W-1:0] cap_z;
    logic        [MAG_W-1:0]   cap_height;
    logic        [MAG_W-1:0]   cap_radius;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
  } rsp_t;

  // Values that ride along the root and quotient pipelines.
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [2:0]         neg;
    logic        [2:0][MAG_W-1:0] mag;
    logic        [MAG_W-1:0]   rad;
    logic                      hit;
    logic                      zero;
  } side_t;

endpackage

// ===== hw/rtl/acp_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage.
module acp_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  acp_pkg::side_t             in_side,
  input  logic [acp_pkg::SQ_W-1:0]   in_s,
  output logic                       out_valid,
  output acp_pkg::side_t             out_side,
  output logic [acp_pkg::MAG_W-1:0]  out_dist
);

  logic                      vld  [acp_pkg::STEPS];
  acp_pkg::side_t            sd   [acp_pkg::STEPS];
  logic [acp_pkg::SQ_W-1:0]  rem  [acp_pkg::STEPS];
  logic [acp_pkg::MAG_W-1:0] root [acp_pkg::STEPS];

  for (genvar t = 0; t < acp_pkg::STEPS; t++) begin : g_stage
    localparam int B = acp_pkg::STEPS - 1 - t;
    logic                      vld_prev;
    acp_pkg::side_t            sd_prev;
    logic [acp_pkg::SQ_W-1:0]  rem_prev;
    logic [acp_pkg::MAG_W-1:0] root_prev;
    logic [acp_pkg::SQ_W-1:0]  trial;
    logic [acp_pkg::SQ_W-1:0]  rem_next;
    logic [acp_pkg::MAG_W-1:0] root_next;

    if (t == 0) begin : g_first
      assign vld_prev  = in_valid;
      assign sd_prev   = in_side;
      assign rem_prev  = in_s;
      assign root_prev = '0;
    end else begin : g_rest
      assign vld_prev  = vld[t-1];
      assign sd_prev   = sd[t-1];
      assign rem_prev  = rem[t-1];
      assign root_prev = root[t-1];
    end

    // Try setting this root bit: cost is root * 2^(B+1) + 2^(2B).
    always_comb begin
      trial = (acp_pkg::SQ_W'(root_prev) << (B + 1)) |
              (acp_pkg::SQ_W'(1) << (2 * B));
      if (rem_prev >= trial) begin
        rem_next  = rem_prev - trial;
        root_next = root_prev | (acp_pkg::MAG_W'(1) << B);
      end else begin
        rem_next  = rem_prev;
        root_next = root_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (en) begin
        vld[t] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[t]   <= sd_prev;
        rem[t]  <= rem_next;
        root[t] <= root_next;
      end
    end
  end

  assign out_valid = vld[acp_pkg::STEPS-1];
  assign out_side  = sd[acp_pkg::STEPS-1];
  assign out_dist  = root[acp_pkg::STEPS-1];

endmodule

// ===== hw/rtl/acp_div_pipe.sv =====
// Three-lane pipelined restoring divider, one quotient bit per register stage.
module acp_div_pipe (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  acp_pkg::side_t                    in_side,
  input  logic [acp_pkg::MAG_W-1:0]         in_den,
  input  logic [2:0][acp_pkg::SQ_W-1:0]     in_num,
  output logic                              out_valid,
  output acp_pkg::side_t                    out_side,
  output logic [2:0][acp_pkg::MAG_W-1:0]    out_quo
);

  logic                              vld [acp_pkg::STEPS];
  acp_pkg::side_t                    sd  [acp_pkg::STEPS];
  logic [acp_pkg::MAG_W-1:0]         den [acp_pkg::STEPS];
  logic [2:0][acp_pkg::MAG_W-1:0]    rem [acp_pkg::STEPS];
  logic [2:0][acp_pkg::MAG_W-1:0]    low [acp_pkg::STEPS];
  logic [2:0][acp_pkg::MAG_W-1:0]    quo [acp_pkg::STEPS];

  for (genvar t = 0; t < acp_pkg::STEPS; t++) begin : g_stage
    logic                           vld_prev;
    acp_pkg::side_t                 sd_prev;
    logic [acp_pkg::MAG_W-1:0]      den_prev;
    logic [2:0][acp_pkg::MAG_W-1:0] rem_prev;
    logic [2:0][acp_pkg::MAG_W-1:0] low_prev;
    logic [2:0][acp_pkg::MAG_W-1:0] quo_prev;
    logic [2:0][acp_pkg::MAG_W-1:0] rem_next;
    logic [2:0][acp_pkg::MAG_W-1:0] low_next;
    logic [2:0][acp_pkg::MAG_W-1:0] quo_next;

    if (t == 0) begin : g_first
      assign vld_prev = in_valid;
      assign sd_prev  = in_side;
      assign den_prev = in_den;
      for (genvar l = 0; l < 3; l++) begin : g_load
        assign rem_prev[l] = in_num[l][acp_pkg::SQ_W-1:acp_pkg::MAG_W];
        assign low_prev[l] = in_num[l][acp_pkg::MAG_W-1:0];
        assign quo_prev[l] = '0;
      end
    end else begin : g_rest
      assign vld_prev = vld[t-1];
      assign sd_prev  = sd[t-1];
      assign den_prev = den[t-1];
      assign rem_prev = rem[t-1];
      assign low_prev = low[t-1];
      assign quo_prev = quo[t-1];
    end

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb begin
      logic [acp_pkg::MAG_W:0] part;
      for (int l = 0; l < 3; l++) begin
        part = {rem_prev[l], low_prev[l][acp_pkg::MAG_W-1]};
        low_next[l] = low_prev[l] << 1;
        if (part >= {1'b0, den_prev}) begin
          rem_next[l] = acp_pkg::MAG_W'(part - {1'b0, den_prev});
          quo_next[l] = {quo_prev[l][acp_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem_next[l] = part[acp_pkg::MAG_W-1:0];
          quo_next[l] = {quo_prev[l][acp_pkg::MAG_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t] <= 1'b0;
      end else if (en) begin
        vld[t] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[t]  <= sd_prev;
        den[t] <= den_prev;
        rem[t] <= rem_next;
        low[t] <= low_next;
        quo[t] <= quo_next;
      end
    end
  end

  assign out_valid = vld[acp_pkg::STEPS-1];
  assign out_side  = sd[acp_pkg::STEPS-1];
  assign out_quo   = quo[acp_pkg::STEPS-1];

endmodule

// ===== hw/rtl/aabb_capsule_collide_push_unit.sv =====
// A request passes through 68 register stages, the first loaded at the edge that accepts it
// (4 geometry stages, 31 square root stages, 1 product stage, 31 divide stages, 1 output).
// Throughput: one request per cycle; the whole pipeline holds while a response waits.
// The root and divide units resolve one bit per stage, which sets the depth.
// Reset clears every stage valid bit and the response valid; no data is cleared.
module aabb_capsule_collide_push_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  acp_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output acp_pkg::rsp_t   rsp
);

  // Saturate a wide signed value to the coordinate range.
  function automatic logic signed [acp_pkg::COORD_W-1:0] sat_coord(
    input logic signed [acp_pkg::EXT_W-1:0] v
  );
    logic [2:0] top;
    top = v[acp_pkg::EXT_W-1:acp_pkg::COORD_W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[acp_pkg::COORD_W-1:0];
    end else if (v[acp_pkg::EXT_W-1]) begin
      return {1'b1, {(acp_pkg::COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(acp_pkg::COORD_W-1){1'b1}}};
    end
  endfunction

  logic en;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  // Stage 1: clamp the centre into the box and find the segment ends.
  // Axis arrays hold x at index 0, y at index 1 and z at index 2.
  logic                             v1;
  logic signed [2:0][acp_pkg::COORD_W-1:0] c1;
  logic signed [2:0][acp_pkg::EXT_W-1:0]   near1;
  logic signed [acp_pkg::EXT_W-1:0] bot1, top1;
  logic        [acp_pkg::MAG_W-1:0] rad1;

  logic signed [2:0][acp_pkg::EXT_W-1:0] near1_next;
  logic signed [acp_pkg::EXT_W-1:0]      bot1_next, top1_next;

  always_comb begin
    logic signed [acp_pkg::EXT_W-1:0] lo, hi, cc;
    logic signed [2:0][acp_pkg::COORD_W-1:0] bmin, cin;
    logic        [2:0][acp_pkg::MAG_W-1:0]   bsz;
    logic signed [acp_pkg::EXT_W-1:0] half, rad, cz;
    bmin = {req.box_min_z, req.box_min_y, req.box_min_x};
    cin  = {req.cap_z, req.cap_y, req.cap_x};
    bsz  = {req.box_size_z, req.box_size_y, req.box_size_x};
    for (int i = 0; i < 3; i++) begin
      lo = acp_pkg::EXT_W'($signed(bmin[i]));
      hi = lo + $signed({3'b000, bsz[i]});
      cc = acp_pkg::EXT_W'($signed(cin[i]));
      if (cc > hi) begin
        near1_next[i] = hi;
      end else if (cc < lo) begin
        near1_next[i] = lo;
      end else begin
        near1_next[i] = cc;
      end
    end
    half = $signed({4'b0000, req.cap_height[acp_pkg::MAG_W-1:1]});
    rad  = $signed({3'b000, req.cap_radius});
    cz   = acp_pkg::EXT_W'(req.cap_z);
    bot1_next = cz - half + rad;
    top1_next = cz + half - rad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= {req.cap_z, req.cap_y, req.cap_x};
      near1 <= near1_next;
      bot1  <= bot1_next;
      top1  <= top1_next;
      rad1  <= req.cap_radius;
    end
  end

  // Stage 2: nearest axis point and per-axis offsets as sign and magnitude.
  logic                                  v2;
  logic signed [2:0][acp_pkg::COORD_W-1:0] c2;
  logic        [2:0][acp_pkg::MAG_W-1:0]   mag2;
  logic        [2:0]                     neg2;
  logic                                  far2;
  logic        [acp_pkg::MAG_W-1:0]      rad2;

  logic [2:0][acp_pkg::MAG_W-1:0] mag2_next;
  logic [2:0]                     neg2_next;
  logic                           far2_next;

  always_comb begin
    logic signed [acp_pkg::EXT_W-1:0]  axis_z;
    logic signed [acp_pkg::DIFF_W-1:0] d;
    logic        [acp_pkg::DIFF_W-1:0] m;
    if ($signed(near1[2]) >= top1) begin
      axis_z = top1;
    end else if ($signed(near1[2]) <= bot1) begin
      axis_z = bot1;
    end else begin
      axis_z = near1[2];
    end
    far2_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (i == 2) begin
        d = acp_pkg::DIFF_W'(axis_z) - acp_pkg::DIFF_W'($signed(near1[i]));
      end else begin
        d = acp_pkg::DIFF_W'($signed(c1[i])) - acp_pkg::DIFF_W'($signed(near1[i]));
      end
      m = d[acp_pkg::DIFF_W-1] ? acp_pkg::DIFF_W'(-d) : acp_pkg::DIFF_W'(d);
      neg2_next[i] = d[acp_pkg::DIFF_W-1];
      mag2_next[i] = m[acp_pkg::MAG_W-1:0];
      if (m[acp_pkg::DIFF_W-1:acp_pkg::MAG_W] != '0) begin
        far2_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2   <= c1;
      mag2 <= mag2_next;
      neg2 <= neg2_next;
      far2 <= far2_next;
      rad2 <= rad1;
    end
  end

  // Stage 3: squares of the offsets and of the radius.
  logic                            v3;
  logic signed [2:0][acp_pkg::COORD_W-1:0] c3;
  logic        [2:0][acp_pkg::MAG_W-1:0]   mag3;
  logic        [2:0]               neg3;
  logic                            far3;
  logic        [acp_pkg::MAG_W-1:0] rad3;
  logic        [2:0][acp_pkg::SQ_W-1:0] sq3;
  logic        [acp_pkg::SQ_W-1:0] r2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3   <= c2;
      mag3 <= mag2;
      neg3 <= neg2;
      far3 <= far2;
      rad3 <= rad2;
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= acp_pkg::SQ_W'(mag2[i]) * acp_pkg::SQ_W'(mag2[i]);
      end
      r2_3 <= acp_pkg::SQ_W'(rad2) * acp_pkg::SQ_W'(rad2);
    end
  end

  // Stage 4: sum of squares, hit test and zero distance check.
  logic                     v4;
  acp_pkg::side_t           side4;
  logic [acp_pkg::SQ_W-1:0] s4;

  acp_pkg::side_t           side4_next;
  logic [acp_pkg::SUM_W-1:0] sum4;

  always_comb begin
    sum4 = acp_pkg::SUM_W'(sq3[0]) + acp_pkg::SUM_W'(sq3[1]) + acp_pkg::SUM_W'(sq3[2]);
    side4_next.cx   = c3[0];
    side4_next.cy   = c3[1];
    side4_next.cz   = c3[2];
    side4_next.neg  = neg3;
    side4_next.mag  = mag3;
    side4_next.rad  = rad3;
    side4_next.hit  = !far3 && (sum4 <= acp_pkg::SUM_W'(r2_3));
    side4_next.zero = (sum4 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side4_next;
      s4    <= sum4[acp_pkg::SQ_W-1:0];
    end
  end

  // Distance through the root pipeline.
  logic                      v_sq;
  acp_pkg::side_t            side_sq;
  logic [acp_pkg::MAG_W-1:0] dist_sq;

  acp_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_side   (side4),
    .in_s      (s4),
    .out_valid (v_sq),
    .out_side  (side_sq),
    .out_dist  (dist_sq)
  );

  // Stage 5: gap to the radius times each offset magnitude.
  logic                             v5;
  acp_pkg::side_t                   side5;
  logic [acp_pkg::MAG_W-1:0]        dist5;
  logic [2:0][acp_pkg::SQ_W-1:0]    prod5;
  logic [acp_pkg::MAG_W-1:0]        gap5;

  assign gap5 = side_sq.rad - dist_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5 <= side_sq;
      dist5 <= dist_sq;
      for (int i = 0; i < 3; i++) begin
        prod5[i] <= acp_pkg::SQ_W'(side_sq.mag[i]) * acp_pkg::SQ_W'(gap5);
      end
    end
  end

  // Push amounts through the divide pipeline.
  logic                          v_dv;
  acp_pkg::side_t                side_dv;
  logic [2:0][acp_pkg::MAG_W-1:0] push_dv;

  acp_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_side   (side5),
    .in_den    (dist5),
    .in_num    (prod5),
    .out_valid (v_dv),
    .out_side  (side_dv),
    .out_quo   (push_dv)
  );

  // Output stage: apply the push or the vertical lift and saturate.
  acp_pkg::rsp_t rsp_next;

  always_comb begin
    logic signed [2:0][acp_pkg::COORD_W-1:0] cc;
    logic signed [acp_pkg::EXT_W-1:0]        r;
    logic signed [acp_pkg::EXT_W-1:0]        p;
    logic signed [2:0][acp_pkg::COORD_W-1:0] res;
    cc = {side_dv.cz, side_dv.cy, side_dv.cx};
    for (int i = 0; i < 3; i++) begin
      r = acp_pkg::EXT_W'($signed(cc[i]));
      if (side_dv.hit && side_dv.zero) begin
        p = (i == 2) ? $signed({3'b000, side_dv.rad}) : '0;
      end else if (side_dv.hit) begin
        p = $signed({3'b000, push_dv[i]});
      end else begin
        p = '0;
      end
      if (side_dv.hit && !side_dv.zero && side_dv.neg[i]) begin
        res[i] = sat_coord(r - p);
      end else begin
        res[i] = sat_coord(r + p);
      end
    end
    rsp_next.hit   = side_dv.hit;
    rsp_next.new_x = res[0];
    rsp_next.new_y = res[1];
    rsp_next.new_z = res[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== tb/aabb_capsule_collide_push_unit_test.sv =====
// Testbench for the box versus capsule collision push unit, self-checking.
module aabb_capsule_collide_push_unit_test;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  acp_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  acp_pkg::rsp_t  rsp;

  acp_pkg::rsp_t  expected_pushes[$];
  int    mismatch_count;
  int    stall_cycles;
  bit    idle_enabled;

  aabb_capsule_collide_push_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Clock.
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Floor of the square root of a wide unsigned value.
  function automatic longint unsigned floor_root(input bit [127:0] s);
    bit [63:0] root;
    bit [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= s) root = cand;
    end
    return root;
  endfunction

  // Clamp a value into the signed coordinate range.
  function automatic logic [acp_pkg::COORD_W-1:0] saturate(input longint v);
    longint top;
    longint bot;
    top = (longint'(1) <<< (acp_pkg::COORD_W - 1)) - 1;
    bot = -top - 1;
    if (v > top) v = top;
    if (v < bot) v = bot;
    return v[acp_pkg::COORD_W-1:0];
  endfunction

  // Resolved capsule position for one box and capsule pair.
  function automatic acp_pkg::rsp_t predict_push(input acp_pkg::req_t r);
    longint bmin[3], bsize[3], c[3], nearest[3], d[3], pos[3];
    longint half, rad, bot_z, top_z, axis_z, root_len, gap, p;
    bit [127:0] sum_sq, rad_sq, mag, quot;
    acp_pkg::rsp_t o;
    bmin[0] = r.box_min_x; bmin[1] = r.box_min_y; bmin[2] = r.box_min_z;
    bsize[0] = longint'({33'd0, r.box_size_x});
    bsize[1] = longint'({33'd0, r.box_size_y});
    bsize[2] = longint'({33'd0, r.box_size_z});
    c[0] = r.cap_x; c[1] = r.cap_y; c[2] = r.cap_z;
    for (int i = 0; i < 3; i++) begin
      pos[i] = c[i];
      nearest[i] = c[i];
      if (nearest[i] > bmin[i] + bsize[i]) nearest[i] = bmin[i] + bsize[i];
      if (nearest[i] < bmin[i]) nearest[i] = bmin[i];
    end
    half = longint'({33'd0, r.cap_height}) >>> 1;
    rad = longint'({33'd0, r.cap_radius});
    bot_z = c[2] - half + rad;
    top_z = c[2] + half - rad;
    // The top end wins when the segment ends cross.
    if (nearest[2] >= top_z) axis_z = top_z;
    else if (nearest[2] <= bot_z) axis_z = bot_z;
    else axis_z = nearest[2];
    d[0] = c[0] - nearest[0];
    d[1] = c[1] - nearest[1];
    d[2] = axis_z - nearest[2];
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
      sum_sq += mag * mag;
    end
    rad_sq = 128'(rad) * 128'(rad);
    o.hit = (sum_sq <= rad_sq);
    if (o.hit) begin
      if (sum_sq == 0) begin
        pos[2] = c[2] + rad;
      end else begin
        root_len = floor_root(sum_sq);
        gap = rad - root_len;
        for (int i = 0; i < 3; i++) begin
          mag = (d[i] < 0) ? 128'(-d[i]) : 128'(d[i]);
          quot = (mag * 128'(gap)) / 128'(root_len);
          p = longint'(quot[63:0]);
          pos[i] = (d[i] < 0) ? c[i] - p : c[i] + p;
        end
      end
    end
    o.new_x = saturate(pos[0]);
    o.new_y = saturate(pos[1]);
    o.new_z = saturate(pos[2]);
    return o;
  endfunction

  // Send one request, with an occasional idle gap before it.
  task automatic send_request(input acp_pkg::req_t r);
    if (idle_enabled && $urandom_range(99) < 7) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_pushes.push_back(predict_push(r));
  endtask

  function automatic acp_pkg::req_t build_request(input longint bx, by, bz, sx, sy, sz,
                                                  input longint cx, cy, cz, h, rad);
    acp_pkg::req_t r;
    r.box_min_x = acp_pkg::COORD_W'(bx);
    r.box_min_y = acp_pkg::COORD_W'(by);
    r.box_min_z = acp_pkg::COORD_W'(bz);
    r.box_size_x = acp_pkg::MAG_W'(sx);
    r.box_size_y = acp_pkg::MAG_W'(sy);
    r.box_size_z = acp_pkg::MAG_W'(sz);
    r.cap_x = acp_pkg::COORD_W'(cx);
    r.cap_y = acp_pkg::COORD_W'(cy);
    r.cap_z = acp_pkg::COORD_W'(cz);
    r.cap_height = acp_pkg::MAG_W'(h);
    r.cap_radius = acp_pkg::MAG_W'(rad);
    return r;
  endfunction

  // Field extremes, all ones and all zeros.
  task automatic test_field_extremes();
    acp_pkg::req_t r;
    r = '0;
    send_request(r);
    r = '1;
    send_request(r);
    r = build_request(-64'sh80000000, -64'sh80000000, -64'sh80000000,
                      64'h7fffffff, 64'h7fffffff, 64'h7fffffff,
                      64'h7fffffff, 64'h7fffffff, 64'h7fffffff,
                      64'h7fffffff, 64'h7fffffff);
    send_request(r);
    r = build_request(64'h7fffffff, 64'h7fffffff, 64'h7fffffff, 0, 0, 0,
                      -64'sh80000000, -64'sh80000000, -64'sh80000000,
                      64'h7fffffff, 64'h7fffffff);
    send_request(r);
    r = build_request(0, 0, 0, 0, 0, 0,
                      -64'sh80000000, 64'h7fffffff, 0, 0, 64'h7fffffff);
    send_request(r);
  endtask

  // Zero distance, touching, crossed segment ends and saturation.
  task automatic test_special_cases();
    // Centre inside the box: zero distance, capsule raised by the radius.
    send_request(build_request(0, 0, 0, 'h100000, 'h100000, 'h100000,
                               'h80000, 'h80000, 'h80000, 'h80000, 'h10000));
    // Zero distance close to the top of the range: new z saturates.
    send_request(build_request(0, 0, 'h7fff0000, 'h100000, 'h100000, 'hffff,
                               'h80000, 'h80000, 'h7fff8000, 'h40000, 'h20000));
    // Exact touch along x.
    send_request(build_request(0, 0, 0, 'h10000, 'h10000, 'h10000,
                               'h30000, 'h8000, 'h8000, 'h80000, 'h20000));
    // Just missing along x.
    send_request(build_request(0, 0, 0, 'h10000, 'h10000, 'h10000,
                               'h30001, 'h8000, 'h8000, 'h80000, 'h20000));
    // Diagonal offset on all three axes, no overlap.
    send_request(build_request(0, 0, 0, 'h10000, 'h10000, 'h10000,
                               'h18000, 'h18000, 'h28000, 'h20000, 'h18000));
    // Radius above half height: segment ends cross, box below and above.
    send_request(build_request(0, 0, 0, 'h10000, 'h10000, 'h10000,
                               'h8000, 'h8000, 'h18000, 'h8000, 'h20000));
    send_request(build_request(0, 0, 'h20000, 'h10000, 'h10000, 'h10000,
                               'h8000, 'h8000, 'h18000, 'h8000, 'h20000));
    // Push toward the negative limit saturates.
    send_request(build_request(-64'sh7fff0000, 0, 0, 'h10000, 'h10000, 'h10000,
                               -64'sh80000000, 'h8000, 'h8000, 'h10000, 'h20000));
    // Odd height, box straddling the capsule's lower end.
    send_request(build_request(-'h10000, -'h10000, -'h30000, 'h20000, 'h20000, 'h10000,
                               'h1000, 'h2000, 0, 'h40001, 'h10000));
  endtask

  // Random pairs, most of them placed close enough to collide.
  task automatic test_random_pairs(input int count);
    acp_pkg::req_t r;
    logic [351:0] raw;
    longint cx, cy, cz, rad;
    for (int n = 0; n < count; n++) begin
      // A long middle stretch runs with no idle gaps.
      idle_enabled = !(n >= count / 3 && n < count / 2);
      if ($urandom_range(9) < 2) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(acp_pkg::req_t)-1:0];
      end else begin
        cx = $signed($urandom);
        cy = $signed($urandom);
        cz = $signed($urandom);
        if ($urandom_range(3) != 0) begin
          cx = cx >>> 8; cy = cy >>> 8; cz = cz >>> 8;
        end
        rad = $urandom_range(0, 'h40000);
        r = build_request(cx - $urandom_range(0, 'h60000), cy - $urandom_range(0, 'h60000),
                          cz - $urandom_range(0, 'h60000),
                          $urandom_range(0, 'h60000), $urandom_range(0, 'h60000),
                          $urandom_range(0, 'h60000),
                          cx, cy, cz, $urandom_range(0, 'h100000), rad);
      end
      send_request(r);
    end
    idle_enabled = 1'b1;
  endtask

  // Response stall and checking against the oldest expectation.
  always @(posedge clk) begin
    acp_pkg::rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !(idle_enabled && $urandom_range(99) < 7);
      if (rsp_valid && rsp_ready) begin
        if (expected_pushes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected response %p", rsp);
        end else begin
          want = expected_pushes.pop_front();
          if (rsp.hit !== want.hit || rsp.new_x !== want.new_x ||
              rsp.new_y !== want.new_y || rsp.new_z !== want.new_z) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p, got %p", want, rsp);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mismatch_count = 0;
    idle_enabled = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_special_cases();
    test_random_pairs(550);
    req_valid <= 1'b0;
    while (expected_pushes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acp_pkg.sv
hw/rtl/acp_sqrt_pipe.sv
hw/rtl/acp_div_pipe.sv
hw/rtl/aabb_capsule_collide_push_unit.sv
tb/aabb_capsule_collide_push_unit_test.sv
